### rtl/ros_pkg.sv
// ============================================================================
// ros_pkg: shared types and codes of the retry outbox slot store
// Operation codes, result codes, register indexes, default policy values and
// the result record that travels from the execute stage to the output port.
// ============================================================================
package ros_pkg;

    // Fixed widths of the request and result fields.
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int HANDLE_W = 16;
    localparam int LEN_W    = 10;

    // Default values of the build-time parameters.
    localparam int SLOTS_DEFAULT       = 8;
    localparam int TOPIC_MAX_DEFAULT   = 128;
    localparam int PAYLOAD_MAX_DEFAULT = 512;
    localparam int HANDLE_BITS_DEFAULT = 16;

    // Policy defaults loaded at reset and by a write of zero.
    localparam logic [31:0] AGE_DEFAULT      = 32'd60000;
    localparam logic [7:0]  ATTEMPTS_DEFAULT = 8'd3;

    // Operation codes.
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DRAIN   = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_STATUS  = 2'd3;

    // The only QoS level that an enqueue may request.
    localparam logic [1:0] QOS_LEVEL_ONE = 2'd1;

    // Enqueue result codes.
    localparam logic [1:0] ENQ_QUEUED      = 2'd0;
    localparam logic [1:0] ENQ_BAD_TOPIC   = 2'd1;
    localparam logic [1:0] ENQ_BAD_PAYLOAD = 2'd2;
    localparam logic [1:0] ENQ_FULL        = 2'd3;

    // Drain result codes; a refused publish reports its code plus the offset.
    localparam logic [2:0] DR_ACCEPTED      = 3'd0;
    localparam logic [2:0] DR_NOT_CONNECTED = 3'd1;
    localparam logic [2:0] DR_EXPIRED       = 3'd2;
    localparam logic [2:0] DR_CODE_OFFSET   = 3'd2;

    // Publish outcome meaning success.
    localparam logic [1:0] PUB_ACCEPTED = 2'd0;

    // Outbox status codes.
    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_HAS     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EXPIRED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_MESSAGES = 2'd0;
    localparam logic [1:0] CFG_MAX_AGE      = 2'd1;
    localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd2;

    // Outcome of the slot scan: lowest active slot and lowest usable free slot.
    typedef struct packed {
        logic             head_found;
        logic [IDX_W-1:0] head_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } scan_t;

    // One result record.
    typedef struct packed {
        logic [1:0]          enqueue_result;
        logic [2:0]          drain_result;
        logic [IDX_W-1:0]    slot_index;
        logic [HANDLE_W-1:0] handle_out;
        logic [LEN_W-1:0]    length_out;
        logic                retain_out;
        logic                publish_issued;
        logic [CNT_W-1:0]    queued_count;
        logic [15:0]         dropped_count;
        logic [15:0]         expired_count;
        logic [1:0]          outbox_state;
    } result_t;

endpackage

### rtl/retry_outbox_slot_store_core.sv
// A request is accepted with the read of its slot memory word; its result is
// registered when it executes, with the read-modify-write of the slot, which waits
// while an unread result holds the output. No new request is accepted until the
// one in flight has executed.
// Reset: all slots free, counters zero, status empty, policies at defaults.
// ============================================================================
// retry_outbox_slot_store_core: fixed slot outbox for at-least-once messages
// Enqueue validates and stores a message in the lowest free slot; drain ages and
// publishes the lowest active slot, frees it if accepted or expired; clear frees all.
// ============================================================================
module retry_outbox_slot_store_core #(
    parameter int SLOTS       = ros_pkg::SLOTS_DEFAULT,
    parameter int TOPIC_MAX   = ros_pkg::TOPIC_MAX_DEFAULT,
    parameter int PAYLOAD_MAX = ros_pkg::PAYLOAD_MAX_DEFAULT,
    parameter int HANDLE_BITS = ros_pkg::HANDLE_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   operation,
    input  logic [31:0]                  now_ms,
    input  logic [ros_pkg::HANDLE_W-1:0] message_handle,
    input  logic [7:0]                   topic_length,
    input  logic                         payload_present,
    input  logic [ros_pkg::LEN_W-1:0]    payload_length,
    input  logic [1:0]                   qos_level,
    input  logic                         retain_flag,
    input  logic                         link_connected,
    input  logic [1:0]                   publish_code,
    // Result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   enqueue_result,
    output logic [2:0]                   drain_result,
    output logic [ros_pkg::IDX_W-1:0]    slot_index,
    output logic [ros_pkg::HANDLE_W-1:0] handle_out,
    output logic [ros_pkg::LEN_W-1:0]    length_out,
    output logic                         retain_out,
    output logic                         publish_issued,
    output logic [ros_pkg::CNT_W-1:0]    queued_count,
    output logic [15:0]                  dropped_count,
    output logic [15:0]                  expired_count,
    output logic [1:0]                   outbox_state,
    // Configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data
);
    import ros_pkg::*;

    // Derived sizes.
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int WORD_W = HW + LEN_W + 1 + 32 + 8;
    localparam logic [CNT_W-1:0] SLOTS_C       = CNT_W'(SLOTS);
    localparam logic [8:0]       TOPIC_LIMIT   = 9'(TOPIC_MAX);
    localparam logic [10:0]      PAYLOAD_LIMIT = 11'(PAYLOAD_MAX);

    // Control and status state.
    logic                busy_reg;
    logic [SLOTS-1:0]    active_reg, active_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [15:0]         refused_reg, refused_next;
    logic [15:0]         expiry_reg, expiry_next;
    logic [1:0]          status_reg, status_next;
    logic [7:0]          max_messages_reg;
    logic [31:0]         max_age_reg;
    logic [7:0]          max_attempts_reg;
    logic                out_valid_reg;
    result_t             out_reg, result_next;

    // Request held for the execute cycle.
    logic [1:0]          op_reg;
    logic [31:0]         now_reg;
    logic [HW-1:0]       handle_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                retain_reg;
    logic                link_reg;
    logic [1:0]          pcode_reg;
    logic [1:0]          check_reg, check_next;
    logic                room_reg;
    scan_t               scan_reg;

    // Scan and memory signals.
    scan_t               scan;
    logic [CNT_W-1:0]    cap;
    logic                accept;
    logic                exec;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [WORD_W-1:0]   rd_data;
    logic [HW-1:0]       rd_handle;
    logic [LEN_W-1:0]    rd_len;
    logic                rd_retain;
    logic [31:0]         rd_qtime;
    logic [7:0]          rd_attempts;
    logic [31:0]         age;
    logic                expired;
    logic [7:0]          attempts_inc;
    logic [CNT_W-1:0]    count_dec;

    // Handshakes: a new request may enter while a result waits at the output.
    // A configuration write is taken only while no request is in flight, and
    // it goes ahead of a request offered in the same cycle.
    assign accept    = in_valid && in_ready;
    assign in_ready  = !busy_reg && !cfg_valid;
    assign exec      = busy_reg && (!out_valid_reg || out_ready);
    assign cfg_ready = !busy_reg;

    // Effective capacity.
    assign cap = ((max_messages_reg == 8'd0) || (CNT_W'(max_messages_reg) > SLOTS_C) ||
                  (max_messages_reg[7])) ? SLOTS_C : CNT_W'(max_messages_reg);

    ros_slot_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .active (active_reg),
        .cap    (cap),
        .scan   (scan)
    );

    // Field checks of an enqueue, in their priority order.
    always_comb
    begin
        if ((topic_length == 8'd0) || (9'(topic_length) >= TOPIC_LIMIT))
        begin
            check_next = ENQ_BAD_TOPIC;
        end
        else if (!payload_present || (11'(payload_length) >= PAYLOAD_LIMIT))
        begin
            check_next = ENQ_BAD_PAYLOAD;
        end
        else if (qos_level != QOS_LEVEL_ONE)
        begin
            check_next = ENQ_BAD_TOPIC;
        end
        else
        begin
            check_next = ENQ_QUEUED;
        end
    end

    // Capture the request and the scan outcome at acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            now_reg    <= now_ms;
            handle_reg <= message_handle[HW-1:0];
            len_reg    <= payload_length;
            retain_reg <= retain_flag;
            link_reg   <= link_connected;
            pcode_reg  <= publish_code;
            check_reg  <= check_next;
            room_reg   <= (count_reg < cap) && scan.free_found;
            scan_reg   <= scan;
        end
    end

    ros_slot_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (ADDR_W),
        .WIDTH  (WORD_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (scan.head_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign {rd_handle, rd_len, rd_retain, rd_qtime, rd_attempts} = rd_data;

    // Ageing and attempt checks of the drain head.
    assign age          = now_reg - rd_qtime;
    assign expired      = (age >= max_age_reg) || (rd_attempts >= max_attempts_reg);
    assign attempts_inc = (rd_attempts == 8'hFF) ? rd_attempts : rd_attempts + 8'd1;
    assign count_dec    = count_reg - CNT_W'(1);

    // Execute: decide the outcome, update slot state and write the memory.
    always_comb
    begin
        active_next  = active_reg;
        count_next   = count_reg;
        refused_next = refused_reg;
        expiry_next  = expiry_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = scan_reg.head_idx[ADDR_W-1:0];
        wr_data      = {rd_handle, rd_len, rd_retain, rd_qtime, attempts_inc};
        result_next  = '0;

        unique case (op_reg)
            OP_ENQUEUE:
            begin
                if (check_reg != ENQ_QUEUED)
                begin
                    result_next.enqueue_result = check_reg;
                end
                else if (!room_reg)
                begin
                    refused_next = (refused_reg == 16'hFFFF) ? refused_reg
                                                             : refused_reg + 16'd1;
                    status_next  = ST_FULL;
                    result_next.enqueue_result = ENQ_FULL;
                end
                else
                begin
                    wr_en       = exec;
                    wr_addr     = scan_reg.free_idx[ADDR_W-1:0];
                    wr_data     = {handle_reg, len_reg, retain_reg, now_reg, 8'd0};
                    active_next[scan_reg.free_idx[ADDR_W-1:0]] = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_HAS;
                    result_next.slot_index = scan_reg.free_idx;
                end
            end
            OP_DRAIN:
            begin
                if (!scan_reg.head_found)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    result_next.slot_index = scan_reg.head_idx;
                    if (expired)
                    begin
                        active_next[scan_reg.head_idx[ADDR_W-1:0]] = 1'b0;
                        count_next  = count_dec;
                        expiry_next = (expiry_reg == 16'hFFFF) ? expiry_reg
                                                               : expiry_reg + 16'd1;
                        status_next = ST_EXPIRED;
                        result_next.drain_result = DR_EXPIRED;
                    end
                    else if (!link_reg)
                    begin
                        result_next.drain_result = DR_NOT_CONNECTED;
                    end
                    else
                    begin
                        result_next.publish_issued = 1'b1;
                        result_next.handle_out     = HANDLE_W'(rd_handle);
                        result_next.length_out     = rd_len;
                        result_next.retain_out     = rd_retain;
                        if (pcode_reg == PUB_ACCEPTED)
                        begin
                            active_next[scan_reg.head_idx[ADDR_W-1:0]] = 1'b0;
                            count_next  = count_dec;
                            status_next = (count_dec == '0) ? ST_EMPTY : ST_HAS;
                            result_next.drain_result = DR_ACCEPTED;
                        end
                        else
                        begin
                            // Refused publish: keep the slot, record the attempt.
                            wr_en = exec;
                            result_next.drain_result = DR_CODE_OFFSET + {1'b0, pcode_reg};
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                active_next = '0;
                count_next  = '0;
                status_next = ST_EMPTY;
            end
            OP_STATUS:
            begin
            end
            default:
            begin
            end
        endcase

        result_next.queued_count  = count_next;
        result_next.dropped_count = refused_next;
        result_next.expired_count = expiry_next;
        result_next.outbox_state  = status_next;
    end

    // Sequencing, slot state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            active_reg       <= '0;
            count_reg        <= '0;
            refused_reg      <= '0;
            expiry_reg       <= '0;
            status_reg       <= ST_EMPTY;
            max_messages_reg <= 8'd0;
            max_age_reg      <= AGE_DEFAULT;
            max_attempts_reg <= ATTEMPTS_DEFAULT;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec)
            begin
                busy_reg <= 1'b0;
            end

            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (exec)
            begin
                active_reg  <= active_next;
                count_reg   <= count_next;
                refused_reg <= refused_next;
                expiry_reg  <= expiry_next;
                status_reg  <= status_next;
            end
            else if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MAX_MESSAGES:
                    begin
                        max_messages_reg <= cfg_data[7:0];
                    end
                    CFG_MAX_AGE:
                    begin
                        max_age_reg <= (cfg_data == 32'd0) ? AGE_DEFAULT : cfg_data;
                    end
                    CFG_MAX_ATTEMPTS:
                    begin
                        max_attempts_reg <= (cfg_data[7:0] == 8'd0) ? ATTEMPTS_DEFAULT
                                                                    : cfg_data[7:0];
                    end
                    default:
                    begin
                    end
                endcase
                if ((cfg_index == CFG_MAX_MESSAGES) || (cfg_index == CFG_MAX_AGE) ||
                    (cfg_index == CFG_MAX_ATTEMPTS))
                begin
                    status_reg <= (count_reg == '0) ? ST_EMPTY : ST_HAS;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign enqueue_result = out_reg.enqueue_result;
    assign drain_result   = out_reg.drain_result;
    assign slot_index     = out_reg.slot_index;
    assign handle_out     = out_reg.handle_out;
    assign length_out     = out_reg.length_out;
    assign retain_out     = out_reg.retain_out;
    assign publish_issued = out_reg.publish_issued;
    assign queued_count   = out_reg.queued_count;
    assign dropped_count  = out_reg.dropped_count;
    assign expired_count  = out_reg.expired_count;
    assign outbox_state   = out_reg.outbox_state;

    // The running slot count always agrees with the active bits.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(active_reg))
        else $error("active slot count out of step with active bits");

    // A drain that found a head must see that slot still active when it executes.
    a_head_active: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (op_reg == OP_DRAIN) && scan_reg.head_found)
            |-> active_reg[scan_reg.head_idx[ADDR_W-1:0]])
        else $error("drain head slot is not active");

    // An issued publish reports either acceptance or a passed-through code.
    a_issue_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.publish_issued)
            |-> ((out_reg.drain_result == DR_ACCEPTED) || (out_reg.drain_result > DR_EXPIRED)))
        else $error("publish issued with a wrong drain result");

    // A queued enqueue leaves the outbox with messages and never above the slot count.
    a_queued_state: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (op_reg == OP_ENQUEUE) && (check_reg == ENQ_QUEUED) && room_reg)
            |=> ((status_reg == ST_HAS) && (count_reg <= SLOTS_C) && (count_reg != '0)))
        else $error("queued enqueue left an inconsistent status");

endmodule

### rtl/ros_slot_mem.sv
// ============================================================================
// ros_slot_mem: slot payload memory
// Single write port and single read port, read data registered. Holds handle,
// length, retain flag, queue time and attempts.
// ============================================================================
module ros_slot_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int WIDTH  = 67
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/ros_slot_scan.sv
// ============================================================================
// ros_slot_scan: slot priority encoder
// Finds the lowest active slot (the drain head) and the lowest free slot that
// lies below the effective capacity (the enqueue target).
// ============================================================================
module ros_slot_scan #(
    parameter int SLOTS = 8
) (
    input  logic [SLOTS-1:0]        active,
    input  logic [ros_pkg::CNT_W-1:0] cap,
    output ros_pkg::scan_t          scan
);
    import ros_pkg::*;

    // Walk from the top down so that the lowest matching slot wins.
    always_comb
    begin
        scan = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (active[i])
            begin
                scan.head_found = 1'b1;
                scan.head_idx   = IDX_W'(i);
            end
            if (!active[i] && (CNT_W'(i) < cap))
            begin
                scan.free_found = 1'b1;
                scan.free_idx   = IDX_W'(i);
            end
        end
    end

endmodule

### sim/retry_outbox_slot_store_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// retry_outbox_slot_store_core_test: self-checking bench for the slot outbox
// A scoreboard object keeps its own copy of the slots, counters and policy
// registers. It predicts every result from the requests as they are accepted
// and checks the results in order. A directed opening is followed by random
// phases under several policy settings and a long receiver hold-off.
// ============================================================================
module retry_outbox_slot_store_core_test;

    import ros_pkg::*;

    // Only the QoS level 1 is accepted; register index 3 does not exist.
    localparam logic [1:0] QOS_AT_LEAST_ONCE = 2'd1;
    localparam logic [1:0] CFG_UNUSED        = 2'd3;

    localparam int HOLD_CYCLES = 120;

    // One request as the sender offers it.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now;
        logic [15:0] handle;
        logic [7:0]  topic_len;
        logic        pay_present;
        logic [9:0]  pay_len;
        logic [1:0]  qos;
        logic        retain;
        logic        link;
        logic [1:0]  pcode;
    } outbox_request_t;

    // Scoreboard: a private copy of the outbox and the results still awaited.
    class outbox_scoreboard;
        logic        slot_busy  [SLOTS_DEFAULT];
        logic [15:0] slot_tag   [SLOTS_DEFAULT];
        logic [9:0]  slot_len   [SLOTS_DEFAULT];
        logic        slot_keep  [SLOTS_DEFAULT];
        logic [31:0] slot_stamp [SLOTS_DEFAULT];
        logic [7:0]  slot_tries [SLOTS_DEFAULT];
        logic [15:0] refusals;
        logic [15:0] expiries;
        logic [1:0]  status;
        logic [7:0]  capacity_reg;
        logic [31:0] age_limit;
        logic [7:0]  tries_limit;
        result_t     awaited[$];
        int          error_count;

        function new();
            for (int i = 0; i < SLOTS_DEFAULT; i++)
                release_slot(i);
            refusals     = '0;
            expiries     = '0;
            status       = ST_EMPTY;
            capacity_reg = '0;
            age_limit    = AGE_DEFAULT;
            tries_limit  = ATTEMPTS_DEFAULT;
            error_count  = 0;
        endfunction

        function void release_slot(int i);
            slot_busy[i]  = 1'b0;
            slot_tag[i]   = '0;
            slot_len[i]   = '0;
            slot_keep[i]  = 1'b0;
            slot_stamp[i] = '0;
            slot_tries[i] = '0;
        endfunction

        function int busy_count();
            int n;
            n = 0;
            for (int i = 0; i < SLOTS_DEFAULT; i++)
                if (slot_busy[i])
                    n++;
            return n;
        endfunction

        // A capacity of zero or above the slot count means every slot.
        function int capacity();
            if (capacity_reg == 0 || capacity_reg > SLOTS_DEFAULT)
                return SLOTS_DEFAULT;
            return capacity_reg;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // A register write; a write of zero loads the policy default.
        function void apply_config(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_MAX_MESSAGES: capacity_reg = data[7:0];
                CFG_MAX_AGE:      age_limit = (data == 0) ? AGE_DEFAULT : data;
                CFG_MAX_ATTEMPTS: tries_limit = (data[7:0] == 0) ? ATTEMPTS_DEFAULT : data[7:0];
                default:          return;
            endcase
            status = (busy_count() == 0) ? ST_EMPTY : ST_HAS;
        endfunction

        // Works out the result of an accepted request and queues it.
        function void note_request(outbox_request_t rq);
            result_t     r;
            int          cap;
            int          found;
            int          head;
            logic [31:0] age;
            r     = '0;
            found = -1;
            head  = -1;
            case (rq.op)
                OP_ENQUEUE: begin
                    // Topic first, then the payload, then the QoS level.
                    if (rq.topic_len == 0 || rq.topic_len >= TOPIC_MAX_DEFAULT)
                        r.enqueue_result = ENQ_BAD_TOPIC;
                    else if (!rq.pay_present || rq.pay_len >= PAYLOAD_MAX_DEFAULT)
                        r.enqueue_result = ENQ_BAD_PAYLOAD;
                    else if (rq.qos != QOS_AT_LEAST_ONCE)
                        r.enqueue_result = ENQ_BAD_TOPIC;
                    else
                    begin
                        cap = capacity();
                        if (busy_count() < cap)
                            for (int i = 0; i < cap; i++)
                                if (!slot_busy[i] && found < 0)
                                    found = i;
                        if (found < 0)
                        begin
                            refusals = bump(refusals);
                            status = ST_FULL;
                            r.enqueue_result = ENQ_FULL;
                        end
                        else
                        begin
                            slot_busy[found]  = 1'b1;
                            slot_tag[found]   = rq.handle;
                            slot_len[found]   = rq.pay_len;
                            slot_keep[found]  = rq.retain;
                            slot_stamp[found] = rq.now;
                            slot_tries[found] = '0;
                            status = ST_HAS;
                            r.enqueue_result = ENQ_QUEUED;
                            r.slot_index = IDX_W'(found);
                        end
                    end
                end
                OP_DRAIN: begin
                    for (int i = 0; i < SLOTS_DEFAULT; i++)
                        if (slot_busy[i] && head < 0)
                            head = i;
                    if (head < 0)
                        status = ST_EMPTY;
                    else
                    begin
                        age = rq.now - slot_stamp[head];
                        r.slot_index = IDX_W'(head);
                        if (age >= age_limit || slot_tries[head] >= tries_limit)
                        begin
                            release_slot(head);
                            expiries = bump(expiries);
                            status = ST_EXPIRED;
                            r.drain_result = DR_EXPIRED;
                        end
                        else if (!rq.link)
                            r.drain_result = DR_NOT_CONNECTED;
                        else
                        begin
                            if (slot_tries[head] != 8'hFF)
                                slot_tries[head]++;
                            r.publish_issued = 1'b1;
                            r.handle_out = slot_tag[head];
                            r.length_out = slot_len[head];
                            r.retain_out = slot_keep[head];
                            if (rq.pcode == PUB_ACCEPTED)
                            begin
                                release_slot(head);
                                status = (busy_count() == 0) ? ST_EMPTY : ST_HAS;
                                r.drain_result = DR_ACCEPTED;
                            end
                            else
                                r.drain_result = DR_CODE_OFFSET + {1'b0, rq.pcode};
                        end
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < SLOTS_DEFAULT; i++)
                        release_slot(i);
                    status = ST_EMPTY;
                end
                default: ;
            endcase
            r.queued_count  = CNT_W'(busy_count());
            r.dropped_count = refusals;
            r.expired_count = expiries;
            r.outbox_state  = status;
            awaited.push_back(r);
        endfunction

        // Every mismatch prints one line and is counted.
        task report(string msg);
            error_count++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s: got %0h, want %0h", name, got, want));
        endtask

        // Compares an accepted result with the oldest one awaited.
        task check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                report("result arrived with nothing awaited");
                return;
            end
            want = awaited.pop_front();
            check_field("enqueue_result", got.enqueue_result, want.enqueue_result);
            check_field("drain_result", got.drain_result, want.drain_result);
            check_field("slot_index", got.slot_index, want.slot_index);
            check_field("handle_out", got.handle_out, want.handle_out);
            check_field("length_out", got.length_out, want.length_out);
            check_field("retain_out", got.retain_out, want.retain_out);
            check_field("publish_issued", got.publish_issued, want.publish_issued);
            check_field("queued_count", got.queued_count, want.queued_count);
            check_field("dropped_count", got.dropped_count, want.dropped_count);
            check_field("expired_count", got.expired_count, want.expired_count);
            check_field("outbox_state", got.outbox_state, want.outbox_state);
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          operation;
    logic [31:0]         now_ms;
    logic [HANDLE_W-1:0] message_handle;
    logic [7:0]          topic_length;
    logic                payload_present;
    logic [LEN_W-1:0]    payload_length;
    logic [1:0]          qos_level;
    logic                retain_flag;
    logic                link_connected;
    logic [1:0]          publish_code;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          enqueue_result;
    logic [2:0]          drain_result;
    logic [IDX_W-1:0]    slot_index;
    logic [HANDLE_W-1:0] handle_out;
    logic [LEN_W-1:0]    length_out;
    logic                retain_out;
    logic                publish_issued;
    logic [CNT_W-1:0]    queued_count;
    logic [15:0]         dropped_count;
    logic [15:0]         expired_count;
    logic [1:0]          outbox_state;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [31:0]         cfg_data;

    outbox_scoreboard book = new();

    // Sender and receiver controls and the bench time; the receiver reads the first two.
    logic        hold_requested = 1'b0;
    logic        no_idle = 1'b0;
    int          calm_left_tx = 0;
    logic [31:0] clock_ms = '0;

    retry_outbox_slot_store_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .now_ms          (now_ms),
        .message_handle  (message_handle),
        .topic_length    (topic_length),
        .payload_present (payload_present),
        .payload_length  (payload_length),
        .qos_level       (qos_level),
        .retain_flag     (retain_flag),
        .link_connected  (link_connected),
        .publish_code    (publish_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .enqueue_result  (enqueue_result),
        .drain_result    (drain_result),
        .slot_index      (slot_index),
        .handle_out      (handle_out),
        .length_out      (length_out),
        .retain_out      (retain_out),
        .publish_issued  (publish_issued),
        .queued_count    (queued_count),
        .dropped_count   (dropped_count),
        .expired_count   (expired_count),
        .outbox_state    (outbox_state),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle gaps: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 31);
        if (r < 18)
            return 0;
        if (r < 29)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic outbox_request_t make_enqueue(logic [7:0] topic, logic present,
                                                     logic [9:0] len, logic [1:0] qos,
                                                     logic [15:0] tag, logic keep,
                                                     logic [31:0] now);
        outbox_request_t rq;
        rq = '0;
        rq.op = OP_ENQUEUE;
        rq.topic_len = topic;
        rq.pay_present = present;
        rq.pay_len = len;
        rq.qos = qos;
        rq.handle = tag;
        rq.retain = keep;
        rq.now = now;
        return rq;
    endfunction

    function automatic outbox_request_t make_drain(logic link, logic [1:0] code,
                                                   logic [31:0] now);
        outbox_request_t rq;
        rq = '0;
        rq.op = OP_DRAIN;
        rq.link = link;
        rq.pcode = code;
        rq.now = now;
        return rq;
    endfunction

    function automatic outbox_request_t make_other(logic [1:0] op);
        outbox_request_t rq;
        rq = '0;
        rq.op = op;
        return rq;
    endfunction

    // Random request: mostly well-formed enqueues and drains, the rest noise.
    function automatic outbox_request_t random_request(logic [31:0] now);
        outbox_request_t rq;
        int pick;
        rq.now = now;
        rq.handle = 16'($urandom);
        rq.topic_len = 8'($urandom);
        rq.pay_present = 1'($urandom);
        rq.pay_len = 10'($urandom);
        rq.qos = 2'($urandom_range(0, 2));
        rq.retain = 1'($urandom);
        rq.link = 1'($urandom);
        rq.pcode = 2'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            rq.op = OP_ENQUEUE;
            if ($urandom_range(0, 4) != 0)
            begin
                rq.topic_len = 8'($urandom_range(1, TOPIC_MAX_DEFAULT - 1));
                rq.pay_present = 1'b1;
                rq.pay_len = 10'($urandom_range(0, PAYLOAD_MAX_DEFAULT - 1));
                rq.qos = QOS_AT_LEAST_ONCE;
            end
        end
        else if (pick < 85)
        begin
            rq.op = OP_DRAIN;
            rq.link = ($urandom_range(0, 6) != 0);
            rq.pcode = $urandom_range(0, 1) ? PUB_ACCEPTED : 2'($urandom_range(1, 3));
        end
        else if (pick < 88)
            rq.op = OP_CLEAR;
        else
            rq.op = OP_STATUS;
        return rq;
    endfunction

    // Offers one request, waits for it to be taken, then idles at random.
    task automatic push_request(input outbox_request_t rq);
        int gap;
        in_valid        <= 1'b1;
        operation       <= rq.op;
        now_ms          <= rq.now;
        message_handle  <= rq.handle;
        topic_length    <= rq.topic_len;
        payload_present <= rq.pay_present;
        payload_length  <= rq.pay_len;
        qos_level       <= rq.qos;
        retain_flag     <= rq.retain;
        link_connected  <= rq.link;
        publish_code    <= rq.pcode;
        do @(negedge clk); while (in_ready !== 1'b1);
        @(posedge clk);
        book.note_request(rq);
        gap = 0;
        if (no_idle)
            gap = 0;
        else if (calm_left_tx > 0)
            calm_left_tx--;
        else
        begin
            if ($urandom_range(0, 24) == 0)
                calm_left_tx = $urandom_range(20, 60);
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering until every awaited result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (book.pending() != 0);
    endtask

    task automatic write_config(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (cfg_ready !== 1'b1);
        @(posedge clk);
        book.apply_config(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Loads all three policies once the outbox is idle. The 8-bit registers
    // get random upper data bits, which the block must ignore.
    task automatic set_policy(input logic [7:0] cap, input logic [31:0] age,
                              input logic [7:0] tries);
        wait_drained();
        repeat (2) @(posedge clk);
        write_config(CFG_MAX_MESSAGES, ($urandom & 32'hFFFF_FF00) | cap);
        write_config(CFG_MAX_AGE, age);
        write_config(CFG_MAX_ATTEMPTS, ($urandom & 32'hFFFF_FF00) | tries);
    endtask

    task automatic run_random(input int count, input int step_max);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 63) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);
            push_request(random_request(clock_ms));
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on demand.
    initial
    begin
        int stall;
        int calm_left_rx;
        calm_left_rx = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (hold_requested)
            begin
                out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_requested = 1'b0;
            end
            else if (no_idle || calm_left_rx > 0)
            begin
                if (calm_left_rx > 0)
                    calm_left_rx--;
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    calm_left_rx = $urandom_range(30, 90);
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Result monitor: values seen at the falling edge are taken at the next
    // rising edge, since neither valid nor ready may change in between.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            book.check_result({enqueue_result, drain_result, slot_index, handle_out,
                               length_out, retain_out, publish_issued, queued_count,
                               dropped_count, expired_count, outbox_state});
    end

    // Main sequence.
    initial
    begin
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        operation       <= OP_STATUS;
        now_ms          <= '0;
        message_handle  <= '0;
        topic_length    <= '0;
        payload_present <= 1'b0;
        payload_length  <= '0;
        qos_level       <= '0;
        retain_flag     <= 1'b0;
        link_connected  <= 1'b0;
        publish_code    <= PUB_ACCEPTED;
        cfg_valid       <= 1'b0;
        cfg_index       <= CFG_MAX_MESSAGES;
        cfg_data        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset policies.
        // An empty drain reports accepted and leaves the outbox empty.
        push_request(make_drain(1'b1, PUB_ACCEPTED, 32'd100));
        // Topic checks, including topic errors masking later ones.
        push_request(make_enqueue(8'd0, 1'b1, 10'd10, QOS_AT_LEAST_ONCE, 16'h1234, 1'b0, 32'd100));
        push_request(make_enqueue(8'(TOPIC_MAX_DEFAULT), 1'b1, 10'd10, QOS_AT_LEAST_ONCE, 16'h1,
                                  1'b0, 32'd100));
        push_request(make_enqueue(8'hFF, 1'b0, 10'd10, 2'd0, 16'h2, 1'b1, 32'd100));
        // Payload checks come before the QoS check.
        push_request(make_enqueue(8'd127, 1'b0, 10'd10, QOS_AT_LEAST_ONCE, 16'h3, 1'b0, 32'd100));
        push_request(make_enqueue(8'd1, 1'b1, 10'(PAYLOAD_MAX_DEFAULT), QOS_AT_LEAST_ONCE, 16'h4,
                                  1'b0, 32'd100));
        push_request(make_enqueue(8'd1, 1'b1, 10'h3FF, 2'd2, 16'h5, 1'b0, 32'd100));
        // A wrong QoS level reports the topic code.
        push_request(make_enqueue(8'd1, 1'b1, 10'd5, 2'd0, 16'h6, 1'b0, 32'd100));
        push_request(make_enqueue(8'd1, 1'b1, 10'd5, 2'd2, 16'h7, 1'b0, 32'd100));
        // Two good messages stamped just before the time wraps.
        push_request(make_enqueue(8'd127, 1'b1, 10'd511, QOS_AT_LEAST_ONCE, 16'hFFFF, 1'b1,
                                  32'hFFFF_FFF0));
        push_request(make_enqueue(8'd1, 1'b1, 10'd0, QOS_AT_LEAST_ONCE, 16'h0000, 1'b0,
                                  32'hFFFF_FFF8));
        push_request(make_other(OP_STATUS));
        // Link down, then refused publishes until the attempts run out.
        push_request(make_drain(1'b0, PUB_ACCEPTED, 32'h0000_0008));
        push_request(make_drain(1'b1, 2'd1, 32'h0000_0010));
        push_request(make_drain(1'b1, 2'd2, 32'h0000_0011));
        push_request(make_drain(1'b1, 2'd3, 32'h0000_0012));
        push_request(make_drain(1'b1, PUB_ACCEPTED, 32'h0000_0013));
        push_request(make_drain(1'b1, PUB_ACCEPTED, 32'h0000_0014));
        // Expiry on age exactly at the limit.
        push_request(make_enqueue(8'd64, 1'b1, 10'd100, QOS_AT_LEAST_ONCE, 16'hA5A5, 1'b1,
                                  32'd1000));
        push_request(make_drain(1'b1, PUB_ACCEPTED, 32'd1000 + AGE_DEFAULT));
        // A small capacity fills up and refuses the next enqueue.
        wait_drained();
        write_config(CFG_MAX_MESSAGES, 32'd2);
        push_request(make_enqueue(8'd2, 1'b1, 10'd1, QOS_AT_LEAST_ONCE, 16'h5A5A, 1'b0, 32'd2000));
        push_request(make_enqueue(8'd3, 1'b1, 10'd2, QOS_AT_LEAST_ONCE, 16'h0F0F, 1'b1, 32'd2001));
        push_request(make_enqueue(8'd4, 1'b1, 10'd3, QOS_AT_LEAST_ONCE, 16'hF0F0, 1'b0, 32'd2002));
        push_request(make_other(OP_CLEAR));
        push_request(make_other(OP_STATUS));

        // Random phases under several policy settings.
        clock_ms = $urandom;
        set_policy(8'd3, 32'd500, 8'd2);
        run_random(50, 20);
        // Long hold-off on the result side while requests keep coming.
        hold_requested = 1'b1;
        no_idle = 1'b1;
        run_random(30, 20);
        no_idle = 1'b0;
        run_random(80, 20);

        set_policy(8'd255, 32'hFFFF_FFFF, 8'd255);
        write_config(CFG_UNUSED, $urandom);
        run_random(160, 1000);

        set_policy(8'd1, 32'd1, 8'd1);
        run_random(80, 1);
        wait_drained();
        run_random(80, 1);

        set_policy(8'd0, 32'd0, 8'd0);
        run_random(160, 200);

        set_policy(8'd8, 32'd300, 8'd4);
        run_random(160, 10);

        set_policy(8'd6, 32'd5000, 8'd3);
        run_random(150, 50);

        wait_drained();
        repeat (8) @(posedge clk);
        if (book.error_count == 0)
            $display("retry_outbox_slot_store_core_test: clean");
        else
            $display("retry_outbox_slot_store_core_test: errors");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #30_000_000;
        $display("retry_outbox_slot_store_core_test: errors");
        $finish;
    end

endmodule

### sim.f
rtl/ros_pkg.sv
rtl/ros_slot_mem.sv
rtl/ros_slot_scan.sv
rtl/retry_outbox_slot_store_core.sv
sim/retry_outbox_slot_store_core_test.sv
